// ===== design/rbb_pkg.sv =====
// Shared types and constants for the rotated box bounding box block
// No dependencies
`timescale 1ns / 1ps

package rbb_pkg;

    localparam int TRIG_BITS   = 30;
    localparam int CORDIC_INIT = 652032874;

    // payload handed from front to back
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        half_width;
        logic [30:0]        half_height;
        logic [1:0]         quarter;
        logic signed [31:0] resid;
    } rbb_item_t;

    // arctangent table, 2^32 per turn
    function automatic logic signed [31:0] atan_turns(input logic [4:0] i);
        case (i)
            5'd0:  atan_turns = 32'h20000000;
            5'd1:  atan_turns = 32'h12E4051E;
            5'd2:  atan_turns = 32'h09FB385B;
            5'd3:  atan_turns = 32'h051111D4;
            5'd4:  atan_turns = 32'h028B0D43;
            5'd5:  atan_turns = 32'h0145D7E1;
            5'd6:  atan_turns = 32'h00A2F61E;
            5'd7:  atan_turns = 32'h00517C55;
            5'd8:  atan_turns = 32'h0028BE53;
            5'd9:  atan_turns = 32'h00145F2F;
            5'd10: atan_turns = 32'h000A2F98;
            5'd11: atan_turns = 32'h000517CC;
            5'd12: atan_turns = 32'h00028BE6;
            5'd13: atan_turns = 32'h000145F3;
            5'd14: atan_turns = 32'h0000A2FA;
            5'd15: atan_turns = 32'h0000517D;
            5'd16: atan_turns = 32'h000028BE;
            5'd17: atan_turns = 32'h0000145F;
            5'd18: atan_turns = 32'h00000A30;
            5'd19: atan_turns = 32'h00000518;
            5'd20: atan_turns = 32'h0000028C;
            5'd21: atan_turns = 32'h00000146;
            5'd22: atan_turns = 32'h000000A3;
            5'd23: atan_turns = 32'h00000051;
            5'd24: atan_turns = 32'h00000029;
            5'd25: atan_turns = 32'h00000014;
            5'd26: atan_turns = 32'h0000000A;
            5'd27: atan_turns = 32'h00000005;
            5'd28: atan_turns = 32'h00000003;
            5'd29: atan_turns = 32'h00000001;
            5'd30: atan_turns = 32'h00000001;
            default: atan_turns = 32'h00000000;
        endcase
    endfunction

endpackage

// ===== design/rbb_front.sv =====
// Front end: input register and angle reduction into quarter and residual
// Depends on rbb_pkg
`timescale 1ns / 1ps

module rbb_front import rbb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [159:0]     in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rbb_item_t        out_item
);

    logic      valid_reg;
    rbb_item_t item_reg, item_next;
    logic [31:0] shifted;

    assign in_ready = !valid_reg || out_ready;

    // split the angle into nearest quarter turn and a residual
    always_comb begin
        shifted               = in_data[157:126] + 32'h20000000;
        item_next.center_x    = in_data[31:0];
        item_next.center_y    = in_data[63:32];
        item_next.half_width  = in_data[94:64];
        item_next.half_height = in_data[125:95];
        item_next.quarter     = shifted[31:30];
        item_next.resid       = {2'b00, shifted[29:0]} - 32'sh20000000;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== design/rbb_queue.sv =====
// Two-entry word queue between front and back
// Depends on rbb_pkg
`timescale 1ns / 1ps

module rbb_queue import rbb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  rbb_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output rbb_item_t out_item
);

    rbb_item_t  mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_reg];

    // storage and pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wr_reg] <= in_item;
    end

endmodule

// ===== design/rbb_cordic_stage.sv =====
// One shift-add rotation step of the sine and cosine pipeline
// Depends on rbb_pkg
`timescale 1ns / 1ps

module rbb_cordic_stage import rbb_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out
);

    logic signed [33:0] dx, dy, at;

    assign dx = y_in >>> STEP;
    assign dy = x_in >>> STEP;
    assign at = 34'(atan_turns(5'(STEP)));

    // rotate toward zero residual
    always_ff @(posedge aclk) begin
        if (en) begin
            if (!z_in[33]) begin
                x_out <= x_in - dx;
                y_out <= y_in + dy;
                z_out <= z_in - at;
            end else begin
                x_out <= x_in + dx;
                y_out <= y_in - dy;
                z_out <= z_in + at;
            end
        end
    end

endmodule

// ===== design/rbb_back.sv =====
// Back end: CORDIC pipeline, corner products, min/max and saturation
// Depends on rbb_pkg, rbb_cordic_stage
`timescale 1ns / 1ps

module rbb_back import rbb_pkg::*; #(
    parameter int ROTATION_STEPS = 24,
    parameter int FRACTION_BITS  = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rbb_item_t        in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [127:0]     out_data
);

    localparam int DEPTH = ROTATION_STEPS + 5;
    localparam int TSH   = TRIG_BITS - FRACTION_BITS;

    // pipeline advances as one; skid-free since output reg holds last
    logic              adv;
    logic [DEPTH-1:0]  vld_reg;
    assign adv      = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    // side data carried alongside the rotation
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        hw;
        logic [30:0]        hh;
        logic [1:0]         q;
    } side_t;

    side_t side_reg [ROTATION_STEPS+1];
    logic signed [33:0] xs [ROTATION_STEPS+1];
    logic signed [33:0] ys [ROTATION_STEPS+1];
    logic signed [33:0] zs [ROTATION_STEPS+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= {in_item.center_x, in_item.center_y, in_item.half_width,
                            in_item.half_height, in_item.quarter};
            xs[0] <= 34'(CORDIC_INIT);
            ys[0] <= '0;
            zs[0] <= 34'(in_item.resid);
            for (int i = 1; i <= ROTATION_STEPS; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_stage
        rbb_cordic_stage #(.STEP(g)) u_stage (
            .aclk(aclk), .en(adv),
            .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]),
            .x_out(xs[g+1]), .y_out(ys[g+1]), .z_out(zs[g+1])
        );
    end

    // trig rounding and quadrant fold
    logic signed [33:0] cr, sr, cq, sq;
    logic signed [17+FRACTION_BITS:0] cos_reg, sin_reg;
    side_t s1_reg, s2_reg, s3_reg;
    always_comb begin
        cr = (xs[ROTATION_STEPS] + (34'sd1 <<< (TSH-1))) >>> TSH;
        sr = (ys[ROTATION_STEPS] + (34'sd1 <<< (TSH-1))) >>> TSH;
        case (side_reg[ROTATION_STEPS].q)
            2'd0:    begin cq = cr;  sq = sr;  end
            2'd1:    begin cq = -sr; sq = cr;  end
            2'd2:    begin cq = -cr; sq = -sr; end
            default: begin cq = sr;  sq = -cr; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cos_reg <= (18+FRACTION_BITS)'(cq);
            sin_reg <= (18+FRACTION_BITS)'(sq);
            s1_reg  <= side_reg[ROTATION_STEPS];
        end
    end

    // four products, one register
    localparam int PW = 50 + FRACTION_BITS;
    logic signed [PW-1:0] pwc_reg, pws_reg, phc_reg, phs_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            pwc_reg <= PW'($signed({1'b0, s1_reg.hw})) * PW'(cos_reg);
            pws_reg <= PW'($signed({1'b0, s1_reg.hw})) * PW'(sin_reg);
            phc_reg <= PW'($signed({1'b0, s1_reg.hh})) * PW'(cos_reg);
            phs_reg <= PW'($signed({1'b0, s1_reg.hh})) * PW'(sin_reg);
            s2_reg  <= s1_reg;
        end
    end

    // extents: x range is +-(|hw c| + |hh s|), rounded per corner
    logic signed [PW+1:0] ax, bx, ay, by;
    logic signed [PW+1:0] hx_reg, lx_reg, hy_reg, ly_reg;
    always_comb begin
        ax = pwc_reg[PW-1] ? -(PW+2)'(pwc_reg) : (PW+2)'(pwc_reg);
        bx = phs_reg[PW-1] ? -(PW+2)'(phs_reg) : (PW+2)'(phs_reg);
        ay = pws_reg[PW-1] ? -(PW+2)'(pws_reg) : (PW+2)'(pws_reg);
        by = phc_reg[PW-1] ? -(PW+2)'(phc_reg) : (PW+2)'(phc_reg);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            hx_reg <= ((ax + bx) + ((PW+2)'(1) <<< (FRACTION_BITS-1))) >>> FRACTION_BITS;
            lx_reg <= ((-(ax + bx)) + ((PW+2)'(1) <<< (FRACTION_BITS-1))) >>> FRACTION_BITS;
            hy_reg <= ((ay + by) + ((PW+2)'(1) <<< (FRACTION_BITS-1))) >>> FRACTION_BITS;
            ly_reg <= ((-(ay + by)) + ((PW+2)'(1) <<< (FRACTION_BITS-1))) >>> FRACTION_BITS;
            s3_reg <= s2_reg;
        end
    end

    // add center and saturate into output word
    function automatic logic [31:0] sat(input logic signed [PW+2:0] v);
        if (v > (PW+3)'(64'sd2147483647))       sat = 32'h7FFFFFFF;
        else if (v < -(PW+3)'(64'sd2147483648)) sat = 32'h80000000;
        else                                    sat = v[31:0];
    endfunction

    logic [127:0] data_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= {sat((PW+3)'(s3_reg.cy) + (PW+3)'(hy_reg)),
                         sat((PW+3)'(s3_reg.cx) + (PW+3)'(hx_reg)),
                         sat((PW+3)'(s3_reg.cy) + (PW+3)'(ly_reg)),
                         sat((PW+3)'(s3_reg.cx) + (PW+3)'(lx_reg))};
        end
    end
    assign out_data = data_reg;

endmodule

// ===== design/rotated_box_bounding_box_top.sv =====
// Top level of the rotated box bounding box block
// Depends on rbb_pkg, rbb_front, rbb_queue, rbb_back
`timescale 1ns / 1ps
// Usage:
//   s_axis: one box per word, tdata = center_x, center_y, half_width,
//   half_height, rotation from bit 0 up. m_axis: one bounding box per
//   word, tdata = min_x, min_y, max_x, max_y.
//   Throughput is one box per cycle while m_axis_tready stays high.
//   A box passes the front register, the queue, the CORDIC input
//   register, one stage per rotation step, then the rounding,
//   product, extent and output registers, in that order.
//   The back pipeline moves as one and holds while m_axis_tready is low
//   with a word waiting; the two-word queue lets the front keep taking
//   input until it fills, then s_axis_tready drops.
//   Reset (aresetn low, synchronous) empties the front, queue and
//   pipeline; no output word is shown until new input arrives.

module rotated_box_bounding_box_top import rbb_pkg::*; #(
    parameter int ROTATION_STEPS = 24,
    parameter int FRACTION_BITS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_x, center_y, half_width, half_height, rotation, zero pad
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // min_x, min_y, max_x, max_y
    output logic [127:0] m_axis_tdata
);

    logic      f_valid, f_ready, q_valid, q_ready;
    rbb_item_t f_item, q_item;

    rbb_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    rbb_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    rbb_back #(.ROTATION_STEPS(ROTATION_STEPS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    // a shown box never has min above max
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:0]) <= $signed(m_axis_tdata[95:64])
                        && $signed(m_axis_tdata[63:32]) <= $signed(m_axis_tdata[127:96])))
        else $error("bounding box min above max");
    // queue full means the front cannot hand over
    a_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        !f_ready |-> q_valid)
        else $error("queue stalls while empty");
    // stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
`endif

endmodule
